/* rtl/core/contiguous_frame_allocator_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the contiguous frame allocator
// Shared shorthands for the concurrent checks on the allocator's ports.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("contiguous frame allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("contiguous frame allocator check failed");

`endif

/* rtl/core/cfa_pkg.sv */
// ----------------------------------------------------------------------------
// cfa_pkg
// Types and codes shared by the contiguous frame allocator modules.
// ----------------------------------------------------------------------------
package cfa_pkg;

	localparam int FRAME_W = 20;
	localparam int COUNT_W = 11;
	localparam int CFG_W   = 20;
	localparam int INDEX_W = 2;

	typedef enum logic [1:0] {
		MODE_INIT    = 2'd0,
		MODE_ALLOC   = 2'd1,
		MODE_RELEASE = 2'd2,
		MODE_MARK    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK           = 2'd0,
		STATUS_NO_SPACE     = 2'd1,
		STATUS_OUT_OF_RANGE = 2'd2,
		STATUS_NOT_HEAD     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CLEAR,
		S_WALK,
		S_FILL
	} seq_state_t;

	// Per-frame map codes. The fourth code is never written and reads as used.
	localparam logic [1:0] FS_FREE = 2'b00;
	localparam logic [1:0] FS_USED = 2'b01;
	localparam logic [1:0] FS_HEAD = 2'b11;

	localparam logic [INDEX_W-1:0] REG_BASE_FRAME    = 2'd0;
	localparam logic [INDEX_W-1:0] REG_FRAMES_IN_USE = 2'd1;
	localparam logic [INDEX_W-1:0] REG_RESERVE_FIRST = 2'd2;

	localparam logic [COUNT_W-1:0] RST_FRAMES_IN_USE = 11'd1024;
	localparam logic [COUNT_W-1:0] FREE_MAX          = '1;

	typedef struct packed {
		logic [FRAME_W-1:0] base_frame;
		logic [COUNT_W-1:0] frames_in_use;
		logic               reserve_first_frame;
	} cfg_t;

endpackage

/* rtl/core/contiguous_frame_allocator_top.sv */
// ----------------------------------------------------------------------------
// contiguous_frame_allocator_top
// First-fit contiguous page frame allocator over a two-bit frame state map.
// ----------------------------------------------------------------------------
// A request is taken at a rising clock edge where start is high and busy is
// low, and its one result is shown on result_frame, status and free_frames for
// exactly one cycle while done is high; the receiver cannot stall it, so it
// must capture the result in that cycle. Right after reset the block runs a
// clearing pass that writes every map entry with busy high; configuration
// writes are taken at any time, but should only be made while the block is
// idle. All timing is set by the single map memory, which is visited one
// entry per cycle through its read and write ports. Init runs the same full
// clearing sweep. Allocate scans from pool frame 0 and, when a run is found,
// fills it; when no run fits it reports no space. Release walks the run from
// its head and mark inaccessible walks count frames. Requests rejected by a
// range or count check, and mark with count zero, finish in the cycle after
// they are taken. The next request may be taken in the cycle where done is
// high.
// ----------------------------------------------------------------------------
module contiguous_frame_allocator_top import cfa_pkg::*; #(
	parameter int MAX_FRAMES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [INDEX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]    cfg_wr_data,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          mode,
	input  logic [FRAME_W-1:0]  frame_no,
	input  logic [COUNT_W-1:0]  count,
	output logic                done,
	output logic [FRAME_W-1:0]  result_frame,
	output logic [1:0]          status,
	output logic [COUNT_W-1:0]  free_frames
);

	localparam int AW = $clog2(MAX_FRAMES);

	cfg_t          cfg_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [1:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [1:0]    mem_rdata;

	// Configuration registers. Writes to an index past the last register are
	// dropped without effect.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_frame          <= '0;
			cfg_q.frames_in_use       <= RST_FRAMES_IN_USE;
			cfg_q.reserve_first_frame <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BASE_FRAME:    cfg_q.base_frame          <= cfg_wr_data[FRAME_W-1:0];
				REG_FRAMES_IN_USE: cfg_q.frames_in_use       <= cfg_wr_data[COUNT_W-1:0];
				REG_RESERVE_FIRST: cfg_q.reserve_first_frame <= cfg_wr_data[0];
				default: begin
				end
			endcase
		end
	end

	// The sequencer owns the free count and all request handling.
	cfa_ctrl #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.start        (start),
		.mode         (mode),
		.frame_no     (frame_no),
		.count        (count),
		.busy         (busy),
		.done         (done),
		.result_frame (result_frame),
		.status       (status),
		.free_frames  (free_frames),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	// The frame state map, one two-bit entry per frame.
	cfa_frame_map #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

/* rtl/core/cfa_frame_map.sv */
// ----------------------------------------------------------------------------
// cfa_frame_map
// Frame state memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cfa_frame_map #(
	parameter int MAX_FRAMES = 1024
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [$clog2(MAX_FRAMES)-1:0]           waddr,
	input  logic [1:0]                              wdata,
	input  logic [$clog2(MAX_FRAMES)-1:0]           raddr,
	output logic [1:0]                              rdata
);

	logic [1:0] mem_q [MAX_FRAMES];
	logic [1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/cfa_ctrl.sv */
// ----------------------------------------------------------------------------
// cfa_ctrl
// Request sequencer: clears the map, scans it first-fit, and walks runs for
// release and mark, reading one entry a cycle and writing back behind.
// ----------------------------------------------------------------------------
module cfa_ctrl import cfa_pkg::*; #(
	parameter int MAX_FRAMES = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cfg_t                              cfg,
	input  logic                              start,
	input  logic [1:0]                        mode,
	input  logic [FRAME_W-1:0]                frame_no,
	input  logic [COUNT_W-1:0]                count,
	output logic                              busy,
	output logic                              done,
	output logic [FRAME_W-1:0]                result_frame,
	output logic [1:0]                        status,
	output logic [COUNT_W-1:0]                free_frames,
	output logic                              mem_we,
	output logic [$clog2(MAX_FRAMES)-1:0]     mem_waddr,
	output logic [1:0]                        mem_wdata,
	output logic [$clog2(MAX_FRAMES)-1:0]     mem_raddr,
	input  logic [1:0]                        mem_rdata
);

	localparam int AW = $clog2(MAX_FRAMES);
	localparam int CW = $clog2(MAX_FRAMES + 1);
	localparam int WW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int DW = FRAME_W + 1;

	seq_state_t         state_q, state_d;
	mode_t              mode_q, mode_d;
	logic [COUNT_W-1:0] cnt_q, cnt_d;
	logic [AW-1:0]      p_q, p_d;
	logic [CW-1:0]      rd_ptr_q, rd_ptr_d;
	logic [CW-1:0]      end_q, end_d;
	logic               vld_s1, vld_d;
	logic [AW-1:0]      addr_s1, addr_d;
	logic [COUNT_W-1:0] run_q, run_d;
	logic [AW-1:0]      start_q, start_d;
	logic [AW-1:0]      fill_ptr_q, fill_ptr_d;
	logic [COUNT_W-1:0] fill_rem_q, fill_rem_d;
	logic [AW-1:0]      clr_ptr_q, clr_ptr_d;
	logic               init_q, init_d;
	logic [COUNT_W-1:0] free_q, free_d;
	logic               done_q, done_d;
	logic [FRAME_W-1:0] result_q, result_d;
	status_t            status_q, status_d;

	logic [WW-1:0]      fiu_w, n_w, cnt_w;
	logic [CW-1:0]      n;
	logic [DW-1:0]      diff, mark_lhs, mark_rhs;
	logic               rel_oor, mark_oor, reserve_now;
	logic [CW-1:0]      p;
	logic               issue, is_free, is_head;
	logic [AW-1:0]      start_sel;

	// Pool size is the smaller of the register and the map depth.
	assign fiu_w = WW'(cfg.frames_in_use);
	assign n_w   = (fiu_w < WW'(MAX_FRAMES)) ? fiu_w : WW'(MAX_FRAMES);
	assign n     = n_w[CW-1:0];
	assign cnt_w = WW'(count);

	assign diff     = {1'b0, frame_no} - {1'b0, cfg.base_frame};
	assign p        = diff[CW-1:0];
	assign rel_oor  = diff[DW-1] || (diff[FRAME_W-1:0] >= FRAME_W'(n));
	assign mark_lhs = {1'b0, frame_no} + DW'(count);
	assign mark_rhs = {1'b0, cfg.base_frame} + DW'(n);
	assign mark_oor = diff[DW-1] || (mark_lhs > mark_rhs);

	assign reserve_now = cfg.reserve_first_frame && (n != '0);

	assign issue     = rd_ptr_q < end_q;
	assign is_free   = mem_rdata == FS_FREE;
	assign is_head   = mem_rdata == FS_HEAD;
	assign start_sel = (run_q == '0) ? addr_s1 : start_q;
	assign mem_raddr = rd_ptr_q[AW-1:0];

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		cnt_d      = cnt_q;
		p_d        = p_q;
		rd_ptr_d   = rd_ptr_q;
		end_d      = end_q;
		vld_d      = 1'b0;
		addr_d     = addr_s1;
		run_d      = run_q;
		start_d    = start_q;
		fill_ptr_d = fill_ptr_q;
		fill_rem_d = fill_rem_q;
		clr_ptr_d  = clr_ptr_q;
		init_d     = init_q;
		free_d     = free_q;
		done_d     = 1'b0;
		result_d   = result_q;
		status_d   = status_q;
		mem_we     = 1'b0;
		mem_waddr  = addr_s1;
		mem_wdata  = FS_FREE;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					mode_d   = mode_t'(mode);
					cnt_d    = count;
					result_d = '0;
					unique case (mode_t'(mode))
						MODE_INIT: begin
							state_d   = S_CLEAR;
							clr_ptr_d = '0;
							init_d    = 1'b1;
						end
						MODE_ALLOC: begin
							if (count == '0 || cnt_w > n_w) begin
								done_d   = 1'b1;
								status_d = STATUS_OUT_OF_RANGE;
							end else if (count > free_q) begin
								done_d   = 1'b1;
								status_d = STATUS_NO_SPACE;
							end else begin
								state_d  = S_WALK;
								rd_ptr_d = '0;
								end_d    = n;
								run_d    = '0;
							end
						end
						MODE_RELEASE: begin
							if (rel_oor) begin
								done_d   = 1'b1;
								status_d = STATUS_OUT_OF_RANGE;
							end else begin
								state_d  = S_WALK;
								rd_ptr_d = p;
								end_d    = n;
								p_d      = p[AW-1:0];
							end
						end
						MODE_MARK: begin
							if (mark_oor) begin
								done_d   = 1'b1;
								status_d = STATUS_OUT_OF_RANGE;
							end else if (count == '0) begin
								done_d   = 1'b1;
								status_d = STATUS_OK;
							end else begin
								state_d  = S_WALK;
								rd_ptr_d = p;
								end_d    = p + CW'(count);
								p_d      = p[AW-1:0];
							end
						end
					endcase
				end
			end

			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_ptr_q;
				mem_wdata = (clr_ptr_q == '0 && init_q && reserve_now) ? FS_USED : FS_FREE;
				clr_ptr_d = clr_ptr_q + AW'(1);
				if (clr_ptr_q == AW'(MAX_FRAMES - 1)) begin
					state_d = S_IDLE;
					if (init_q) begin
						done_d   = 1'b1;
						status_d = STATUS_OK;
						free_d   = COUNT_W'(n) - (reserve_now ? COUNT_W'(1) : COUNT_W'(0));
					end
				end
			end

			S_WALK: begin
				// Reads run one entry ahead of the write-back, so a write never
				// targets the entry being read in the same cycle.
				if (issue) begin
					rd_ptr_d = rd_ptr_q + CW'(1);
					vld_d    = 1'b1;
					addr_d   = rd_ptr_q[AW-1:0];
				end
				if (vld_s1) begin
					unique case (mode_q)
						MODE_ALLOC: begin
							if (is_free) begin
								start_d = start_sel;
								run_d   = run_q + COUNT_W'(1);
								if (run_q + COUNT_W'(1) == cnt_q) begin
									state_d    = S_FILL;
									fill_ptr_d = start_sel;
									fill_rem_d = cnt_q;
								end
							end else begin
								run_d = '0;
							end
						end
						MODE_RELEASE: begin
							if (addr_s1 == p_q && !is_head) begin
								state_d  = S_IDLE;
								done_d   = 1'b1;
								status_d = STATUS_NOT_HEAD;
							end else if (addr_s1 != p_q && (is_free || is_head)) begin
								state_d  = S_IDLE;
								done_d   = 1'b1;
								status_d = STATUS_OK;
							end else begin
								mem_we    = 1'b1;
								mem_wdata = FS_FREE;
								if (free_q != FREE_MAX) begin
									free_d = free_q + COUNT_W'(1);
								end
							end
						end
						MODE_MARK: begin
							if (is_free) begin
								mem_we    = 1'b1;
								mem_wdata = (addr_s1 == p_q) ? FS_HEAD : FS_USED;
								if (free_q != '0) begin
									free_d = free_q - COUNT_W'(1);
								end
							end
						end
						MODE_INIT: begin
						end
					endcase
				end else if (!issue) begin
					state_d  = S_IDLE;
					done_d   = 1'b1;
					status_d = (mode_q == MODE_ALLOC) ? STATUS_NO_SPACE : STATUS_OK;
				end
			end

			S_FILL: begin
				mem_we     = 1'b1;
				mem_waddr  = fill_ptr_q;
				mem_wdata  = (fill_ptr_q == start_q) ? FS_HEAD : FS_USED;
				fill_ptr_d = fill_ptr_q + AW'(1);
				fill_rem_d = fill_rem_q - COUNT_W'(1);
				if (fill_rem_q == COUNT_W'(1)) begin
					state_d  = S_IDLE;
					done_d   = 1'b1;
					status_d = STATUS_OK;
					result_d = cfg.base_frame + FRAME_W'(start_q);
					free_d   = free_q - cnt_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			mode_q     <= MODE_INIT;
			cnt_q      <= '0;
			p_q        <= '0;
			rd_ptr_q   <= '0;
			end_q      <= '0;
			vld_s1     <= 1'b0;
			addr_s1    <= '0;
			run_q      <= '0;
			start_q    <= '0;
			fill_ptr_q <= '0;
			fill_rem_q <= '0;
			clr_ptr_q  <= '0;
			init_q     <= 1'b0;
			free_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			mode_q     <= mode_d;
			cnt_q      <= cnt_d;
			p_q        <= p_d;
			rd_ptr_q   <= rd_ptr_d;
			end_q      <= end_d;
			vld_s1     <= vld_d;
			addr_s1    <= addr_d;
			run_q      <= run_d;
			start_q    <= start_d;
			fill_ptr_q <= fill_ptr_d;
			fill_rem_q <= fill_rem_d;
			clr_ptr_q  <= clr_ptr_d;
			init_q     <= init_d;
			free_q     <= free_d;
			done_q     <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
		status_q <= status_d;
	end

	assign busy         = state_q != S_IDLE;
	assign done         = done_q;
	assign result_frame = result_q;
	assign status       = status_q;
	assign free_frames  = free_q;

endmodule

/* rtl/core/cfa_checker.sv */
// ----------------------------------------------------------------------------
// cfa_port_checker
// Port-level checks on request handling and results of the allocator.
// ----------------------------------------------------------------------------
`include "contiguous_frame_allocator_top_defines.svh"

module cfa_port_checker import cfa_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [FRAME_W-1:0] result_frame,
	input logic [1:0]         status,
	input logic [COUNT_W-1:0] free_frames
);

	// A taken request either finishes at once or keeps the block busy.
	`CFA_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy || done)

	// A result always follows a taken request or ongoing work.
	`CFA_ASSERT_IMP(a_done_cause, clk, arst_n, done, $past(busy) || $past(start))

	// Failed requests never hand out a frame.
	`CFA_ASSERT_IMP(a_err_no_frame, clk, arst_n, done && (status != STATUS_OK),
		result_frame == '0)

	// An allocation that found no space leaves the free count alone.
	`CFA_ASSERT_IMP(a_no_space_keeps, clk, arst_n, done && (status == STATUS_NO_SPACE),
		$stable(free_frames))

endmodule

bind contiguous_frame_allocator_top cfa_port_checker u_cfa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.result_frame (result_frame),
	.status       (status),
	.free_frames  (free_frames)
);

/* test/cfa_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cfa_checker
// Tracks the allocator's map, free count and register settings, predicts the
// outcome of every request the allocator takes and compares it with the
// result that comes back.
// ----------------------------------------------------------------------------
module cfa_checker import cfa_pkg::*; #(
	parameter int MAX_FRAMES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [INDEX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]    cfg_wr_data,
	input  logic                start,
	input  logic                busy,
	input  logic [1:0]          mode,
	input  logic [FRAME_W-1:0]  frame_no,
	input  logic [COUNT_W-1:0]  count,
	input  logic                done,
	input  logic [FRAME_W-1:0]  result_frame,
	input  logic [1:0]          status,
	input  logic [COUNT_W-1:0]  free_frames,
	output int                  fail_count,
	output int                  outstanding
);

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		status_t            st;
		logic [COUNT_W-1:0] free;
	} frame_result_t;

	frame_result_t      pending_results[$];
	logic [1:0]         frame_map [MAX_FRAMES];
	logic [COUNT_W-1:0] free_cnt;
	cfg_t               cfg;
	int                 errors;

	function automatic void drop_free();
		if (free_cnt != '0)
			free_cnt = free_cnt - 1'b1;
	endfunction

	function automatic void add_free();
		if (free_cnt != FREE_MAX)
			free_cnt = free_cnt + 1'b1;
	endfunction

	// Applies one request to the tracked map and returns what it must report.
	function automatic frame_result_t allocate_frames(mode_t op, logic [FRAME_W-1:0] fno,
			logic [COUNT_W-1:0] cnt);
		frame_result_t r;
		int n, f, b, c, p, i, run, head_at;
		bit found, stop;
		n = (int'(cfg.frames_in_use) < MAX_FRAMES) ? int'(cfg.frames_in_use) : MAX_FRAMES;
		f = fno;
		b = cfg.base_frame;
		c = cnt;
		run = 0;
		head_at = 0;
		found = 1'b0;
		stop = 1'b0;
		r.frame = '0;
		r.st = STATUS_OK;
		case (op)
			MODE_INIT: begin
				for (i = 0; i < MAX_FRAMES; i++)
					frame_map[i] = FS_FREE;
				free_cnt = COUNT_W'(n);
				if (cfg.reserve_first_frame && n > 0) begin
					frame_map[0] = FS_USED;
					drop_free();
				end
			end
			MODE_ALLOC: begin
				if (c == 0 || c > n) begin
					r.st = STATUS_OUT_OF_RANGE;
				end else if (c > int'(free_cnt)) begin
					r.st = STATUS_NO_SPACE;
				end else begin
					for (i = 0; i < n && !found; i++) begin
						if (frame_map[i] == FS_FREE) begin
							if (run == 0)
								head_at = i;
							run++;
							if (run == c)
								found = 1'b1;
						end else begin
							run = 0;
						end
					end
					if (!found) begin
						r.st = STATUS_NO_SPACE;
					end else begin
						frame_map[head_at] = FS_HEAD;
						for (i = head_at + 1; i < head_at + c; i++)
							frame_map[i] = FS_USED;
						repeat (c) drop_free();
						r.frame = cfg.base_frame + FRAME_W'(head_at);
					end
				end
			end
			MODE_RELEASE: begin
				if (f < b || f - b >= n) begin
					r.st = STATUS_OUT_OF_RANGE;
				end else begin
					p = f - b;
					if (frame_map[p] != FS_HEAD) begin
						r.st = STATUS_NOT_HEAD;
					end else begin
						frame_map[p] = FS_FREE;
						add_free();
						// The run ends at a free frame, the next head or the pool end.
						for (i = p + 1; i < n && !stop; i++) begin
							if (frame_map[i] == FS_FREE || frame_map[i] == FS_HEAD) begin
								stop = 1'b1;
							end else begin
								frame_map[i] = FS_FREE;
								add_free();
							end
						end
					end
				end
			end
			default: begin
				if (f < b || f + c > b + n) begin
					r.st = STATUS_OUT_OF_RANGE;
				end else begin
					p = f - b;
					for (i = p; i < p + c; i++) begin
						if (frame_map[i] == FS_FREE) begin
							frame_map[i] = (i == p) ? FS_HEAD : FS_USED;
							drop_free();
						end
					end
				end
			end
		endcase
		r.free = free_cnt;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_FRAMES; i++)
				frame_map[i] = FS_FREE;
			free_cnt = '0;
			cfg = '{base_frame: '0, frames_in_use: RST_FRAMES_IN_USE, reserve_first_frame: 1'b1};
			pending_results.delete();
			errors = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			// A result finishing in the cycle a new request is taken belongs to
			// an older request, so it is compared before the new one is queued.
			if (done) begin
				if (pending_results.size() == 0) begin
					if (errors < 10)
						$display("%t: result with no request waiting: frame %h status %0d free %0d",
							$realtime, result_frame, status, free_frames);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (result_frame !== want.frame || status !== want.st ||
							free_frames !== want.free) begin
						if (errors < 10)
							$display("%t: expected frame %h status %0d free %0d, got frame %h status %0d free %0d",
								$realtime, want.frame, want.st, want.free,
								result_frame, status, free_frames);
						errors++;
					end
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_BASE_FRAME:    cfg.base_frame = cfg_wr_data[FRAME_W-1:0];
					REG_FRAMES_IN_USE: cfg.frames_in_use = cfg_wr_data[COUNT_W-1:0];
					REG_RESERVE_FIRST: cfg.reserve_first_frame = cfg_wr_data[0];
					default: ;
				endcase
			end
			if (start && !busy)
				pending_results.push_back(allocate_frames(mode_t'(mode), frame_no, count));
			fail_count <= errors;
			outstanding <= pending_results.size();
		end
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the contiguous frame allocator: directed corner
// requests, then bursts of random requests over several pool settings, with
// the checker beside the block predicting and comparing every result.
// ----------------------------------------------------------------------------
module tb;
	import cfa_pkg::*;

	localparam int MAX_FRAMES = 1024;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [INDEX_W-1:0] cfg_index;
	logic [CFG_W-1:0]   cfg_wr_data;
	logic               start;
	logic               busy;
	logic [1:0]         mode;
	logic [FRAME_W-1:0] frame_no;
	logic [COUNT_W-1:0] count;
	logic               done;
	logic [FRAME_W-1:0] result_frame;
	logic [1:0]         status;
	logic [COUNT_W-1:0] free_frames;

	int fail_count;
	int outstanding;

	// The stimulus keeps its own view of the pool so that most frame numbers
	// it picks land inside it.
	logic [FRAME_W-1:0] pool_base;
	int                 pool_frames;
	bit                 pool_reserve;

	// Heads handed out by recent allocations; releases mostly aim at these so
	// that whole runs get freed instead of bouncing off as not-head.
	logic [FRAME_W-1:0] live_heads[$];

	contiguous_frame_allocator_top #(
		.MAX_FRAMES(MAX_FRAMES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.start(start),
		.busy(busy),
		.mode(mode),
		.frame_no(frame_no),
		.count(count),
		.done(done),
		.result_frame(result_frame),
		.status(status),
		.free_frames(free_frames)
	);

	cfa_checker #(
		.MAX_FRAMES(MAX_FRAMES)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.start(start),
		.busy(busy),
		.mode(mode),
		.frame_no(frame_no),
		.count(count),
		.done(done),
		.result_frame(result_frame),
		.status(status),
		.free_frames(free_frames),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A successful allocation is the only request that reports a nonzero
	// frame, so any such result is remembered as a release target.
	always @(posedge clk) begin
		if (arst_n && done && status == STATUS_OK && result_frame != '0 &&
				live_heads.size() < 32)
			live_heads.push_back(result_frame);
	end

	// Presents one request and holds it until the block takes it. On return
	// the request has just been accepted and start is still high, so a
	// following request can go out back to back.
	task automatic issue(mode_t op, logic [FRAME_W-1:0] fno, logic [COUNT_W-1:0] cnt);
		start <= 1'b1;
		mode <= op;
		frame_no <= fno;
		count <= cnt;
		do @(posedge clk); while (busy);
	endtask

	// Lets the block drain and then loads all three registers. Every request
	// returns exactly one result, so nothing outstanding means the block is
	// idle.
	task automatic set_pool(logic [FRAME_W-1:0] base, int frames, bit reserve);
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_BASE_FRAME;
		cfg_wr_data <= CFG_W'(base);
		@(posedge clk);
		cfg_index <= REG_FRAMES_IN_USE;
		cfg_wr_data <= CFG_W'(frames);
		@(posedge clk);
		cfg_index <= REG_RESERVE_FIRST;
		cfg_wr_data <= CFG_W'(reserve);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pool_base = base;
		pool_frames = (frames < MAX_FRAMES) ? frames : MAX_FRAMES;
		pool_reserve = reserve;
		live_heads.delete();
	endtask

	// Builds one random request. Most of the traffic is well-formed (small
	// allocations, releases of real heads, marks inside the pool) so that the
	// map fills and fragments; the rest is out-of-range and odd values.
	task automatic random_request();
		int pick, k, p, span;
		mode_t op;
		logic [FRAME_W-1:0] fno;
		logic [COUNT_W-1:0] cnt;
		pick = $urandom_range(0, 99);
		fno = FRAME_W'($urandom);
		cnt = COUNT_W'($urandom);
		if (pick < 3) begin
			op = MODE_INIT;
		end else if (pick < 45) begin
			op = MODE_ALLOC;
			k = $urandom_range(0, 9);
			span = (pool_frames < 8) ? pool_frames : 8;
			if (k < 7)
				cnt = COUNT_W'($urandom_range(1, span));
			else if (k < 9)
				cnt = COUNT_W'($urandom_range(1, pool_frames));
		end else if (pick < 78) begin
			op = MODE_RELEASE;
			k = $urandom_range(0, 99);
			if (live_heads.size() > 0 && k < 65) begin
				p = $urandom_range(0, live_heads.size() - 1);
				fno = live_heads[p];
				live_heads.delete(p);
			end else if (k < 90) begin
				fno = pool_base + FRAME_W'($urandom_range(0, pool_frames - 1));
			end
		end else begin
			op = MODE_MARK;
			if ($urandom_range(0, 99) < 85) begin
				p = $urandom_range(0, pool_frames - 1);
				span = (pool_frames - p < 4) ? pool_frames - p : 4;
				fno = pool_base + FRAME_W'(p);
				cnt = COUNT_W'($urandom_range(0, span));
			end
		end
		issue(op, fno, cnt);
	endtask

	// Random traffic in bursts: back-to-back requests, then usually a gap of
	// random length so that idle start cycles fall on every stage of the
	// block's work.
	task automatic run_traffic(int items);
		int left, burst;
		left = items;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && left > 0) begin
				random_request();
				burst--;
				left--;
			end
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_BASE_FRAME;
		cfg_wr_data = '0;
		start = 1'b0;
		mode = MODE_INIT;
		frame_no = '0;
		count = '0;
		pool_base = '0;
		pool_frames = MAX_FRAMES;
		pool_reserve = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// The block clears its map right after reset with busy high; the
		// first register writes wait for that pass to finish.
		do @(posedge clk); while (busy);

		// Directed part on a sixteen-frame pool at frame 16. The first
		// allocation comes before any init, while the free count is still
		// zero, so it must report no space.
		set_pool(20'd16, 16, 1'b1);
		issue(MODE_ALLOC, '0, 11'd1);
		issue(MODE_INIT, '0, '0);
		issue(MODE_ALLOC, '0, 11'd0);          // count zero is out of range
		issue(MODE_ALLOC, '0, 11'd2047);       // count far above the pool
		issue(MODE_ALLOC, '0, 11'd15);         // takes every frame but the reserved one
		issue(MODE_ALLOC, '0, 11'd1);          // nothing left
		issue(MODE_RELEASE, 20'd17, '0);
		issue(MODE_RELEASE, 20'd17, '0);       // now free, so not a head
		issue(MODE_RELEASE, 20'd16, '0);       // the reserved frame is used, not a head
		issue(MODE_RELEASE, 20'd15, '0);       // just below the pool
		issue(MODE_RELEASE, 20'd32, '0);       // just past the pool end
		issue(MODE_MARK, 20'd20, 11'd4);
		issue(MODE_MARK, 20'd18, 11'd4);       // overlaps: only the free frames are claimed
		issue(MODE_MARK, 20'd28, 11'd5);       // runs past the pool end
		issue(MODE_MARK, 20'd16, 11'd0);       // empty range changes nothing
		issue(MODE_ALLOC, '0, 11'd3);
		issue(MODE_RELEASE, 20'd18, '0);       // walk stops at the next head
		issue(MODE_RELEASE, 20'd24, '0);       // walk stops at a free frame
		issue(MODE_MARK, 20'd28, 11'd4);
		issue(MODE_RELEASE, 20'd28, '0);       // walk stops at the pool end

		// Pool at the top of the frame space: the reported head frame wraps
		// around to zero.
		set_pool(20'hFFFFF, 8, 1'b0);
		issue(MODE_INIT, '0, '0);
		issue(MODE_ALLOC, '0, 11'd1);
		issue(MODE_ALLOC, '0, 11'd2);
		issue(MODE_ALLOC, '0, 11'd5);
		issue(MODE_RELEASE, 20'hFFFFF, '0);

		// Random phases across pool sizes and bases, the extremes included.
		set_pool('0, 1024, 1'b1);
		issue(MODE_INIT, '0, '0);
		run_traffic(120);

		set_pool(20'hFFFFF, 8, 1'b0);
		issue(MODE_INIT, '0, '0);
		run_traffic(100);

		set_pool(FRAME_W'($urandom), 64, 1'($urandom));
		issue(MODE_INIT, '0, '0);
		run_traffic(200);

		set_pool(FRAME_W'($urandom), 8, 1'b1);
		issue(MODE_INIT, '0, '0);
		run_traffic(150);

		// Shrink to 32 frames and init, then grow to the full size without
		// another init: frames above the old size stay as they were and the
		// free count no longer matches the map, so it can saturate.
		set_pool(FRAME_W'($urandom), 32, 1'b1);
		issue(MODE_INIT, '0, '0);
		run_traffic(60);
		set_pool(pool_base, 1024, pool_reserve);
		run_traffic(100);

		set_pool(FRAME_W'($urandom), 8 * $urandom_range(1, 16), 1'($urandom));
		issue(MODE_INIT, '0, '0);
		run_traffic(200);

		set_pool(FRAME_W'($urandom), 1024, 1'b0);
		issue(MODE_INIT, '0, '0);
		run_traffic(100);

		// Drain, then keep watching long enough to catch a stray result from
		// the longest scan the block can make.
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (2200) @(posedge clk);

		if (fail_count == 0)
			$display("contiguous_frame_allocator_top: match");
		else
			$display("contiguous_frame_allocator_top: mismatch");
		$finish;
	end

	// Safety net far beyond the slowest correct run: every request scanning
	// the whole map plus the longest gaps.
	initial begin
		#100_000_000;
		$display("contiguous_frame_allocator_top: mismatch");
		$finish;
	end

endmodule
